/* rtl/core/substring_deletion_filter_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the substring deletion filter
// Shared property forms, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_DELETION_FILTER_UNIT_ASSERT_SVH
`define SUBSTRING_DELETION_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sdf_pkg.sv */
// ----------------------------------------------------------------------------
// Substring deletion filter package
// Register indexes and the types passed between the front and back parts.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int PLEN_REG_W  = 4;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 2'd1;

  // Width of the pending count as reported in the status group.
  localparam int PEND_W = 4;

  // One queued command from the front part.
  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
  } sdf_cmd_t;

  // Status of the back part, seen by the top level.
  typedef struct packed {
    logic              idle;
    logic [PEND_W-1:0] pend_count;
  } sdf_status_t;

endpackage

/* rtl/core/sdf_front.sv */
// ----------------------------------------------------------------------------
// Substring deletion filter front part
// Accepts input transfers, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sdf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [7:0]        in_char,
  output logic              q_valid,
  output sdf_pkg::sdf_cmd_t q_cmd,
  input  logic              q_pop
);
  import sdf_pkg::*;

  sdf_cmd_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       take;
  sdf_cmd_t   cmd_in;

  // The queue is full when both entries are taken.
  assign in_stall = count_r[1];
  assign take     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = entry_r[rd_ptr_r];

  // Classify the item: an end of string carries no character.
  always_comb begin
    cmd_in.is_end = in_action;
    cmd_in.ch     = in_action ? 8'd0 : in_char;
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = take ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, take} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/sdf_back.sv */
// ----------------------------------------------------------------------------
// Substring deletion filter back part
// Scans the pending buffer against the pattern one step a cycle unless stalled
// and drives the output register through a one-result hold stage that sets the last flag.
// ----------------------------------------------------------------------------
module sdf_back #(
  parameter int MAX_PAT = 8,
  parameter int LEN_W   = 4,
  parameter int BUF_W   = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LEN_W-1:0]     plen,
  input  logic [BUF_W-1:0]     pat,
  input  logic                 q_valid,
  input  sdf_pkg::sdf_cmd_t    q_cmd,
  output logic                 q_pop,
  output sdf_pkg::sdf_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_char,
  output logic                 out_end_of_string,
  output logic                 out_last
);
  import sdf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       held_char_r, held_char_nxt;
  logic             held_eos_r, held_eos_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_eos_r, out_eos_nxt;
  logic             out_last_r, out_last_nxt;

  logic             can_push, blocked, push, push_last;
  logic             emit, emit_eos, done, match;
  logic [7:0]       emit_char;
  logic [BUF_W-1:0] buf_shift_one, buf_shift_pat, buf_ins;

  assign can_push = !out_valid_r || !out_stall;
  assign blocked  = held_valid_r && !can_push;

  assign buf_shift_one = buf_r >> 8;
  assign buf_shift_pat = buf_r >> {plen, 3'b000};

  // Compare the pending prefix with the pattern, byte by byte in parallel.
  always_comb begin
    match = (plen != '0);
    for (int k = 0; k < MAX_PAT; k++) begin
      if ((LEN_W'(k) < len_r) && (LEN_W'(k) < plen) &&
          (buf_r[k*8 +: 8] != pat[k*8 +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Append the new character behind the pending ones.
  always_comb begin
    buf_ins = buf_r;
    for (int i = 0; i < MAX_PAT; i++) begin
      if (LEN_W'(i) == len_r) begin
        buf_ins[i*8 +: 8] = q_cmd.ch;
      end
    end
  end

  // Sequencer for one scan step, flush step or release of the held result.
  always_comb begin
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    len_nxt        = len_r;
    held_char_nxt  = held_char_r;
    held_eos_nxt   = held_eos_r;
    held_valid_nxt = held_valid_r;
    q_pop          = 1'b0;
    push           = 1'b0;
    push_last      = 1'b0;
    emit           = 1'b0;
    emit_eos       = 1'b0;
    emit_char      = buf_r[7:0];
    done           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_end) begin
            state_nxt = S_FLUSH;
          end else begin
            buf_nxt   = buf_ins;
            len_nxt   = len_r + LEN_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          // A partial match waits for more characters; a full one is dropped.
          if (len_r < plen) begin
            done = 1'b1;
          end else begin
            buf_nxt = buf_shift_pat;
            len_nxt = len_r - plen;
            if (len_r == plen) begin
              done = 1'b1;
            end
          end
        end else if (!blocked) begin
          emit    = 1'b1;
          buf_nxt = buf_shift_one;
          len_nxt = len_r - LEN_W'(1);
          if (len_r == LEN_W'(1)) begin
            state_nxt = S_FIN;
          end
        end
        if (done) begin
          state_nxt = held_valid_r ? S_FIN : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!blocked) begin
          emit = 1'b1;
          if (len_r != '0) begin
            buf_nxt = buf_shift_one;
            len_nxt = len_r - LEN_W'(1);
          end else begin
            emit_char = 8'd0;
            emit_eos  = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        // The held result is the final one of this item.
        if (can_push) begin
          push           = 1'b1;
          push_last      = 1'b1;
          held_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new result displaces the held one into the output register.
    if (emit) begin
      push           = held_valid_r;
      push_last      = 1'b0;
      held_char_nxt  = emit_char;
      held_eos_nxt   = emit_eos;
      held_valid_nxt = 1'b1;
    end
  end

  // Output register loads from the hold stage.
  always_comb begin
    out_valid_nxt = push || (out_valid_r && out_stall);
    out_char_nxt  = push ? held_char_r : out_char_r;
    out_eos_nxt   = push ? held_eos_r : out_eos_r;
    out_last_nxt  = push ? push_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    buf_r       <= buf_nxt;
    held_char_r <= held_char_nxt;
    held_eos_r  <= held_eos_nxt;
    out_char_r  <= out_char_nxt;
    out_eos_r   <= out_eos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_end_of_string = out_eos_r;
  assign out_last          = out_last_r;

  assign status.idle       = (state_r == S_IDLE);
  assign status.pend_count = PEND_W'(len_r);

endmodule

/* rtl/core/substring_deletion_filter_unit.sv */
// ----------------------------------------------------------------------------
// Substring deletion filter unit
// Passes a character stream on with every leftmost, non-overlapping
// occurrence of the configured pattern removed.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    in_action, in_char
//   out_     output     out_valid/out_stall  out_char, out_end_of_string, out_last
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// An item leaves the input queue in the idle state; the scan then drops one
// match or emits one character per step, and a final step releases the held
// result as the last one when a result is held.
// Reset is synchronous and active low; there is no clearing pass.
// The two-entry queue keeps accepting while the output is stalled, until both entries are taken.
// ----------------------------------------------------------------------------
`include "substring_deletion_filter_unit_assert.svh"

module substring_deletion_filter_unit #(
  parameter int MAX_PAT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [7:0]                     in_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_char,
  output logic                           out_end_of_string,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [sdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sdf_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAT + 1);
  localparam int BUF_W = MAX_PAT * 8;

  logic [PLEN_REG_W-1:0] pat_len_r, pat_len_nxt;
  logic [CFG_DATA_W-1:0] pat_bytes_r, pat_bytes_nxt;
  logic [LEN_W-1:0]      plen;
  logic                  q_valid;
  logic                  q_pop;
  sdf_cmd_t              q_cmd;
  sdf_status_t           bk_status;

  // Configuration registers.
  always_comb begin
    pat_len_nxt   = pat_len_r;
    pat_bytes_nxt = pat_bytes_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pat_len_nxt   = cfg_wdata[PLEN_REG_W-1:0];
        CFG_PATTERN_BYTES:  pat_bytes_nxt = cfg_wdata;
        default: begin
          pat_len_nxt   = pat_len_r;
          pat_bytes_nxt = pat_bytes_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      pat_bytes_r <= '0;
    end else begin
      pat_len_r   <= pat_len_nxt;
      pat_bytes_r <= pat_bytes_nxt;
    end
  end

  // A length beyond the buffer saturates to the full pattern size.
  assign plen = (pat_len_r > PLEN_REG_W'(MAX_PAT)) ? LEN_W'(MAX_PAT)
                                                   : LEN_W'(pat_len_r);

  sdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_char   (in_char),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  sdf_back #(
    .MAX_PAT (MAX_PAT),
    .LEN_W   (LEN_W),
    .BUF_W   (BUF_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .plen              (plen),
    .pat               (pat_bytes_r[BUF_W-1:0]),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .status            (bk_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .out_end_of_string (out_end_of_string),
    .out_last          (out_last)
  );

  // Checks on the filter's own logic.
  `SDF_ASSERT_NOW(a_eos_is_last, out_valid && out_end_of_string, out_last && (out_char == 8'd0), "end marker must be last and carry a zero byte")
  `SDF_ASSERT_NOW(a_pend_bound, bk_status.idle, bk_status.pend_count < PEND_W'(MAX_PAT), "pending run must be shorter than the pattern buffer")
  `SDF_ASSERT_NEXT(a_idle_hold, bk_status.idle && !q_valid, bk_status.idle, "back part left idle with an empty queue")

endmodule

/* test/substring_deletion_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// Substring deletion filter unit testbench
// Streams strings into the filter and checks every surviving character and
// end marker against a predictor kept in the bench. A short directed
// sequence covers the corner cases. Random phases follow, each with its own
// pattern, and the strings in them are built mostly from copies and partial
// copies of that pattern. Both channels stall and idle at random.
// ----------------------------------------------------------------------------
module substring_deletion_filter_unit_tb;
  import sdf_pkg::*;

  localparam int MAX_PAT         = 8;
  localparam int DRAIN_CYCLES    = 3 * (MAX_PAT + 2);
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PRINT_CAP       = 40;
  localparam int RANDOM_PHASES   = 13;
  localparam int PHASE_ITEMS     = 30;

  // Register indexes that map to nothing; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       last;
  } filt_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   in_action = 1'b0;
  logic [7:0]             in_char   = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_char;
  logic                   out_end_of_string;
  logic                   out_last;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Text waiting to be sent, and the characters and markers due back.
  sdf_cmd_t     text_q[$];
  sdf_cmd_t     next_cmd;
  filt_result_t surviving_q[$];

  // Predictor copy of the registers and the pending buffer.
  logic [3:0]  pat_len   = 4'd0;
  logic [63:0] pat_bytes = 64'd0;
  logic [7:0]  pend_chars [0:MAX_PAT-2];
  int          pend_count = 0;

  logic [7:0]  alphabet [0:2];
  int          mismatch_count    = 0;
  int          burst_left        = 1;
  int          gap_left          = 0;
  int          hold_off_requests = 0;
  int          hold_off_served   = 0;
  int          hold_off_left     = 0;
  int          mode_left         = 0;
  stall_mode_t stall_mode        = STALL_NONE;
  int          quiet_cycles      = 0;

  substring_deletion_filter_unit #(
    .MAX_PAT(MAX_PAT)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_char          (in_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_end_of_string(out_end_of_string),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out what one accepted character or end of string lets through.
  // A leading run that matches the whole pattern is dropped; a run that only
  // matches a prefix stays pending; otherwise its first character escapes.
  function automatic void filter_text_item(input logic is_end, input logic [7:0] ch);
    logic [7:0]   work [0:MAX_PAT-1];
    filt_result_t found [0:MAX_PAT];
    int           n_work;
    int           n_found;
    int           plen;
    int           m;
    int           k;
    bit           ok;
    n_work  = pend_count;
    n_found = 0;
    plen    = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
    for (k = 0; k < n_work; k++) work[k] = pend_chars[k];
    if (is_end) begin
      for (k = 0; k < n_work; k++) begin
        found[n_found] = {work[k], 1'b0, 1'b0};
        n_found++;
      end
      found[n_found] = {8'h00, 1'b1, 1'b0};
      n_found++;
      n_work = 0;
    end else begin
      work[n_work] = ch;
      n_work++;
      while (n_work > 0) begin
        m  = (n_work < plen) ? n_work : plen;
        ok = (plen > 0);
        for (k = 0; k < m; k++) begin
          if (work[k] != pat_bytes[8*k +: 8]) ok = 1'b0;
        end
        if (ok && n_work < plen) break;
        if (ok) begin
          for (k = 0; k + plen < n_work; k++) work[k] = work[k + plen];
          n_work -= plen;
        end else begin
          found[n_found] = {work[0], 1'b0, 1'b0};
          n_found++;
          for (k = 0; k + 1 < n_work; k++) work[k] = work[k + 1];
          n_work--;
        end
      end
    end
    for (k = 0; k < n_work; k++) pend_chars[k] = work[k];
    pend_count = n_work;
    for (k = 0; k < n_found; k++) begin
      if (k == n_found - 1) found[k].last = 1'b1;
      surviving_q.push_back(found[k]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Compares the result transfer on the output with the oldest expectation.
  task automatic check_result();
    filt_result_t want;
    if (surviving_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result char %02h eos %0b last %0b",
                                out_char, out_end_of_string, out_last));
    end else begin
      want = surviving_q.pop_front();
      if (out_char !== want.ch)
        report_mismatch($sformatf("out_char got %02h want %02h", out_char, want.ch));
      if (out_end_of_string !== want.eos)
        report_mismatch($sformatf("out_end_of_string got %0b want %0b",
                                  out_end_of_string, want.eos));
      if (out_last !== want.last)
        report_mismatch($sformatf("out_last got %0b want %0b", out_last, want.last));
    end
  endtask

  // Sender: offers queued text in bursts of random length with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) filter_text_item(in_action, in_char);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || text_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_cmd = text_q.pop_front();
          in_valid  <= 1'b1;
          in_action <= next_cmd.is_end;
          in_char   <= next_cmd.ch;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls on a pattern that
  // changes mode when a random countdown runs out, with a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_off_served != hold_off_requests) begin
        hold_off_served <= hold_off_requests;
        hold_off_left   <= HOLD_OFF_CYCLES;
        out_stall       <= 1'b1;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall     <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= stall_mode_t'($urandom_range(0, 3));
          mode_left  <= $urandom_range(20, 60);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= !out_stall;
        endcase
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PATTERN_LENGTH: pat_len = data[3:0];
      CFG_PATTERN_BYTES:  pat_bytes = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until all text is sent and every result is back, then lets the
  // block finish any character that produced nothing.
  task automatic wait_idle();
    do @(negedge clk); while (text_q.size() != 0 || in_valid || surviving_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_char(input logic [7:0] ch);
    text_q.push_back({1'b0, ch});
  endtask

  task automatic push_end(input logic [7:0] junk);
    text_q.push_back({1'b1, junk});
  endtask

  // Builds text mostly from whole and partial copies of the pattern, with
  // alphabet characters, foreign bytes and ends of string mixed in.
  task automatic queue_random_text(input int n_items);
    int added;
    int plen_eff;
    int pick;
    int cut;
    int k;
    added = 0;
    while (added < n_items) begin
      plen_eff = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
      pick     = $urandom_range(0, 99);
      if (pick < 8) begin
        push_end(8'($urandom_range(0, 255)));
        added++;
      end else if (pick < 45 && plen_eff > 0) begin
        for (k = 0; k < plen_eff; k++) push_char(pat_bytes[8*k +: 8]);
        added += plen_eff;
      end else if (pick < 65 && plen_eff > 1) begin
        cut = $urandom_range(1, plen_eff - 1);
        for (k = 0; k < cut; k++) push_char(pat_bytes[8*k +: 8]);
        added += cut;
      end else if (pick < 95) begin
        push_char(alphabet[$urandom_range(0, 2)]);
        added++;
      end else begin
        push_char(8'($urandom_range(0, 255)));
        added++;
      end
    end
  endtask

  initial begin
    int          ph;
    int          len_sel;
    int          k;
    logic [63:0] word;
    for (k = 0; k < MAX_PAT - 1; k++) pend_chars[k] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset pattern length is zero: everything passes, zero byte included.
    push_char(8'h00);
    push_char(8'hFF);
    push_end(8'hFF);
    wait_idle();

    // Two-byte pattern; unused upper bytes set to make sure they are ignored.
    write_reg(CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_6261);
    write_reg(CFG_PATTERN_LENGTH, 64'h2);
    push_char("x");
    push_char("a");
    push_char("a");
    push_char("b");
    push_char("a");
    push_end(8'h00);
    push_end(8'h5A);
    push_char("a");
    wait_idle();

    // Pattern shortened while a character is pending: the pending run now
    // matches in full and is dropped. Unmapped indexes must change nothing.
    write_reg(CFG_PATTERN_LENGTH, 64'h1);
    write_reg(CFG_UNMAPPED_A, {$urandom, $urandom});
    push_char("c");
    push_char("a");
    push_end(8'h80);
    wait_idle();

    // Oversized length saturates to the full eight bytes; a late mismatch
    // releases the whole pending run at once.
    write_reg(CFG_PATTERN_BYTES, 64'h3736_3534_3332_3130);
    write_reg(CFG_PATTERN_LENGTH, 64'hF);
    write_reg(CFG_UNMAPPED_B, '1);
    for (k = 0; k < MAX_PAT - 1; k++) push_char(8'(8'h30 + k));
    push_char("9");
    for (k = 0; k < 3; k++) push_char(8'(8'h30 + k));
    wait_idle();

    // Length zero with characters pending: they go out ahead of the new one.
    write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    push_char("z");
    push_end(8'hA5);
    wait_idle();

    // Random phases. Every fourth phase changes only the length, so pending
    // text is checked again against the altered pattern.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph % 4 != 3) begin
        if ($urandom_range(0, 3) == 0) begin
          word = {$urandom, $urandom};
          for (k = 0; k < 3; k++) alphabet[k] = word[8*k +: 8];
        end else begin
          for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(0, 255));
          for (k = 0; k < 8; k++) word[8*k +: 8] = alphabet[$urandom_range(0, 2)];
        end
        write_reg(CFG_PATTERN_BYTES, word);
      end
      case (ph)
        0:       len_sel = MAX_PAT;
        1:       len_sel = 1;
        2:       len_sel = 0;
        3:       len_sel = 15;
        default: len_sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, MAX_PAT);
      endcase
      word      = {$urandom, $urandom};
      word[3:0] = len_sel[3:0];
      write_reg(CFG_PATTERN_LENGTH, word);
      // One phase starts with the receiver held off so the block backs up.
      if (ph == 5) hold_off_requests++;
      queue_random_text(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
